FILE: hw/rtl/slg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slg_pkg: shared types, constants and table functions
// Holds the register map, reset weights and the sRGB decode function used
// to build the linear-light and threshold tables at elaboration.
// ----------------------------------------------------------------------------
package slg_pkg;

   localparam int WEIGHT_W = 16;
   localparam int CHAN_W   = 8;
   localparam int LEVELS   = 256;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_WEIGHT_RED   = 2'd0;
   localparam reg_index_type REG_WEIGHT_GREEN = 2'd1;
   localparam reg_index_type REG_WEIGHT_BLUE  = 2'd2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RESET   = 16'd6968;
   localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RESET = 16'd23434;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RESET  = 16'd2366;

   localparam logic [63:0] Q_ONE = 64'd2147483648;

   function automatic logic [63:0] pow5_q31(input logic [63:0] y);
      logic [63:0] p;
      p = y;
      for (int i = 0; i < 4; i++) begin
         p = (p * y) >> 31;
      end
      return p;
   endfunction

   // linear value of encoded level n/510, unsigned Q1.frac_bits
   function automatic logic [63:0] decode_half(input logic [63:0] n, input int frac_bits);
      logic [63:0] num;
      logic [63:0] t;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] q;
      if (n <= 64'd20) begin
         num = (n * 64'd100) << frac_bits;
         return (num + 64'd329460) / 64'd658920;
      end
      t = ((n * 64'd1000 + 64'd28050) << 31) / 64'd538050;
      if (t > Q_ONE) begin
         t = Q_ONE;
      end
      lo = 64'd0;
      hi = Q_ONE;
      for (int it = 0; it < 34; it++) begin
         if (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            if (pow5_q31(mid) <= t) begin
               lo = mid;
            end else begin
               hi = mid - 64'd1;
            end
         end
      end
      q = (t * t) >> 31;
      q = (q * lo) >> 31;
      q = (q * lo) >> 31;
      q = (q + (64'd1 << (30 - frac_bits))) >> (31 - frac_bits);
      return q;
   endfunction

endpackage

FILE: hw/rtl/srgb_luminance_gray_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_luminance_gray_top: sRGB pixel to 8-bit gray by relative luminance
// Decodes each channel to linear light, weights and sums the three values
// and encodes the sum back to an 8-bit gamma-encoded gray level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive req_red, req_green, req_blue with start high; the
//   word is taken at a rising edge where start is high and busy is low.
//   busy never rises, so one pixel can be taken on every clock.
//   Result channel: rsp_gray_level is shown for one cycle with rsp_valid
//   high. The receiver cannot stall; it must take every word as shown.
//   Path: each pixel passes the input register, the product register, the
//   sum register and the search registers in turn. Throughput is one pixel per
//   cycle, set by the fully pipelined path: input register, three parallel
//   multipliers, one adder stage and an 8-stage search over the sorted
//   encode thresholds (one level bit per stage).
//   Weights are written over APB (psel/penable/pwrite) at byte addresses
//   0, 4 and 8. The user must write them only while no pixel is in
//   flight; the block does not enforce it. Reset (synchronous, active high)
//   empties the pipeline and loads the default weights 6968, 23434 and 2366.
// ----------------------------------------------------------------------------
module srgb_luminance_gray_top
   import slg_pkg::*;
#(
   parameter int LINEAR_FRAC_BITS = 16,
   parameter int WEIGHT_FRAC_BITS = 15
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   output logic                rsp_valid,
   output logic [CHAN_W-1:0]   rsp_gray_level,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam int LIN_W  = LINEAR_FRAC_BITS + 1;
   localparam int PROD_W = LIN_W + WEIGHT_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int THR_W  = LIN_W + WEIGHT_FRAC_BITS;
   localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;
   localparam int STAGES = CHAN_W;

   logic [LIN_W-1:0] lin_rom [LEVELS];
   logic [CMP_W-1:0] thr_rom [LEVELS];

   for (genvar g = 0; g < LEVELS; g++) begin : g_rom
      localparam logic [LIN_W-1:0] LIN_VAL =
         LIN_W'(decode_half(64'(2 * g), LINEAR_FRAC_BITS));
      localparam logic [CMP_W-1:0] THR_VAL = (g == 0) ? '0 :
         (CMP_W'(decode_half(64'(2 * g - 1), LINEAR_FRAC_BITS)) << WEIGHT_FRAC_BITS);
      assign lin_rom[g] = LIN_VAL;
      assign thr_rom[g] = THR_VAL;
   end

   logic [WEIGHT_W-1:0] weight_red_ff, weight_green_ff, weight_blue_ff;
   logic                csr_write;
   reg_index_type       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_red_ff   <= WEIGHT_RED_RESET;
         weight_green_ff <= WEIGHT_GREEN_RESET;
         weight_blue_ff  <= WEIGHT_BLUE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_WEIGHT_RED:   weight_red_ff   <= pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_GREEN: weight_green_ff <= pwdata[WEIGHT_W-1:0];
            REG_WEIGHT_BLUE:  weight_blue_ff  <= pwdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WEIGHT_RED:   prdata = DATA_W'(weight_red_ff);
         REG_WEIGHT_GREEN: prdata = DATA_W'(weight_green_ff);
         REG_WEIGHT_BLUE:  prdata = DATA_W'(weight_blue_ff);
         default:          prdata = '0;
      endcase
   end

   // input stage
   logic              accept;
   logic              in_valid_ff;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
      end
   end

   // decode and weight
   logic              prod_valid_ff;
   logic [PROD_W-1:0] prod_red_ff, prod_green_ff, prod_blue_ff;
   logic [PROD_W-1:0] prod_red_in, prod_green_in, prod_blue_in;

   assign prod_red_in   = PROD_W'(lin_rom[red_ff])   * PROD_W'(weight_red_ff);
   assign prod_green_in = PROD_W'(lin_rom[green_ff]) * PROD_W'(weight_green_ff);
   assign prod_blue_in  = PROD_W'(lin_rom[blue_ff])  * PROD_W'(weight_blue_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_red_ff   <= prod_red_in;
      prod_green_ff <= prod_green_in;
      prod_blue_ff  <= prod_blue_in;
   end

   // sum
   logic             sum_valid_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   assign sum_in = SUM_W'(prod_red_ff) + SUM_W'(prod_green_ff) + SUM_W'(prod_blue_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // encode: resolve one level bit per stage, most significant first
   logic              srch_valid_ff [STAGES];
   logic [CMP_W-1:0]  srch_sum_ff   [STAGES-1];
   logic [CHAN_W-1:0] srch_level_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_srch
      localparam int BIT = STAGES - 1 - s;
      logic              valid_prev;
      logic [CMP_W-1:0]  sum_prev;
      logic [CHAN_W-1:0] level_prev;
      logic [CHAN_W-1:0] cand;
      logic [CHAN_W-1:0] level_in;

      if (s == 0) begin : g_first
         assign valid_prev = sum_valid_ff;
         assign sum_prev   = CMP_W'(sum_ff);
         assign level_prev = '0;
      end else begin : g_next
         assign valid_prev = srch_valid_ff[s-1];
         assign sum_prev   = srch_sum_ff[s-1];
         assign level_prev = srch_level_ff[s-1];
      end

      assign cand     = level_prev | (CHAN_W'(1) << BIT);
      assign level_in = (sum_prev >= thr_rom[cand]) ? cand : level_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            srch_valid_ff[s] <= 1'b0;
         end else begin
            srch_valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         srch_level_ff[s] <= level_in;
      end

      if (s < STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            srch_sum_ff[s] <= sum_prev;
         end
      end
   end

   assign rsp_valid      = srch_valid_ff[STAGES-1];
   assign rsp_gray_level = srch_level_ff[STAGES-1];

endmodule

FILE: bench/slg_gray_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slg_gray_checker: scoreboard for the sRGB luminance gray converter
// Follows the weight registers from APB writes, predicts the gray level of
// each accepted pixel from its own decode and threshold tables, and checks
// every result word in order. Register read data is checked as well.
// ----------------------------------------------------------------------------
module slg_gray_checker
   import slg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic                rsp_valid,
   input  logic [CHAN_W-1:0]   rsp_gray_level,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   input  logic [DATA_W-1:0]   prdata,
   input  logic                pready,
   output int                  mismatch_count,
   output int                  gray_in_flight,
   output int                  gray_checked
);

   localparam int LIN_FRAC = 16;
   localparam int WT_FRAC  = 15;
   localparam logic [63:0] UNITY_Q31 = 64'd1 << 31;

   logic [16:0]         linear_of_level [LEVELS];
   logic [16:0]         midpoint_linear [LEVELS];
   logic [WEIGHT_W-1:0] wt_red;
   logic [WEIGHT_W-1:0] wt_green;
   logic [WEIGHT_W-1:0] wt_blue;
   logic [CHAN_W-1:0]   gray_expected_q [$];

   function automatic logic [63:0] fifth_power_q31(input logic [63:0] y);
      logic [63:0] acc;
      acc = y;
      for (int i = 0; i < 4; i++) begin
         acc = (acc * y) >> 31;
      end
      return acc;
   endfunction

   // linear light of encoded level half/510, unsigned Q1.16
   function automatic logic [16:0] srgb_to_linear(input int half);
      logic [63:0] t;
      logic [63:0] root;
      logic [63:0] cand;
      logic [63:0] q;
      if (half <= 20) begin
         return 17'((((64'(half) * 64'd100) << LIN_FRAC) + 64'd329460) / 64'd658920);
      end
      t = ((64'(half) * 64'd1000 + 64'd28050) << 31) / 64'd538050;
      if (t > UNITY_Q31) begin
         t = UNITY_Q31;
      end
      // largest root with root^5 <= t, bit by bit
      if (fifth_power_q31(UNITY_Q31) <= t) begin
         root = UNITY_Q31;
      end else begin
         root = '0;
         for (int b = 30; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (fifth_power_q31(cand) <= t) begin
               root = cand;
            end
         end
      end
      q = (t * t) >> 31;
      q = (q * root) >> 31;
      q = (q * root) >> 31;
      return 17'((q + (64'd1 << (30 - LIN_FRAC))) >> (31 - LIN_FRAC));
   endfunction

   function automatic logic [CHAN_W-1:0] predict_gray_level(input logic [CHAN_W-1:0] r,
                                                            input logic [CHAN_W-1:0] g,
                                                            input logic [CHAN_W-1:0] b);
      logic [63:0] luminance;
      int level;
      luminance = 64'(wt_red) * 64'(linear_of_level[r])
                + 64'(wt_green) * 64'(linear_of_level[g])
                + 64'(wt_blue) * 64'(linear_of_level[b]);
      level = 0;
      for (int k = 1; k < LEVELS; k++) begin
         if (luminance >= (64'(midpoint_linear[k]) << WT_FRAC)) begin
            level++;
         end
      end
      return CHAN_W'(level);
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, want, got);
      end
   endtask

   initial begin
      mismatch_count = 0;
      gray_in_flight = 0;
      gray_checked = 0;
      wt_red = WEIGHT_RED_RESET;
      wt_green = WEIGHT_GREEN_RESET;
      wt_blue = WEIGHT_BLUE_RESET;
      midpoint_linear[0] = '0;
      for (int i = 0; i < LEVELS; i++) begin
         linear_of_level[i] = srgb_to_linear(2 * i);
         if (i > 0) begin
            midpoint_linear[i] = srgb_to_linear(2 * i - 1);
         end
      end
   end

   always @(posedge clock) begin : watch
      reg_index_type       idx;
      logic [CHAN_W-1:0]   want;
      logic [WEIGHT_W-1:0] held;
      bit                  mapped;
      if (reset) begin
         wt_red = WEIGHT_RED_RESET;
         wt_green = WEIGHT_GREEN_RESET;
         wt_blue = WEIGHT_BLUE_RESET;
         gray_expected_q.delete();
         gray_in_flight = 0;
      end else begin
         idx = reg_index_type'(paddr >> 2);
         if (rsp_valid) begin
            if (gray_expected_q.size() == 0) begin
               flag_mismatch("gray word with none pending:", -1, rsp_gray_level);
            end else begin
               want = gray_expected_q.pop_front();
               gray_in_flight--;
               gray_checked++;
               if (rsp_gray_level !== want) begin
                  flag_mismatch("gray_level", want, rsp_gray_level);
               end
            end
         end
         if (start && !busy) begin
            gray_expected_q.push_back(predict_gray_level(req_red, req_green, req_blue));
            gray_in_flight++;
         end
         if (psel && penable && pready) begin
            mapped = 1'b1;
            case (idx)
               REG_WEIGHT_RED:   held = wt_red;
               REG_WEIGHT_GREEN: held = wt_green;
               REG_WEIGHT_BLUE:  held = wt_blue;
               default:          mapped = 1'b0;
            endcase
            if (pwrite) begin
               case (idx)
                  REG_WEIGHT_RED:   wt_red = pwdata[WEIGHT_W-1:0];
                  REG_WEIGHT_GREEN: wt_green = pwdata[WEIGHT_W-1:0];
                  REG_WEIGHT_BLUE:  wt_blue = pwdata[WEIGHT_W-1:0];
                  default: ;
               endcase
            end else if (mapped && prdata[WEIGHT_W-1:0] !== held) begin
               flag_mismatch("weight read", held, prdata[WEIGHT_W-1:0]);
            end
         end
      end
   end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for srgb_luminance_gray_top
// Streams pixels with random gaps under a series of weight settings (reset,
// full scale, zero, all ones, random), including writes to the unused
// register slot; the scoreboard beside the block does the checking.
// ----------------------------------------------------------------------------
module tb_top
   import slg_pkg::*;
();

   localparam reg_index_type REG_UNMAPPED = 2'd3;
   localparam int RANDOM_PHASES    = 7;
   localparam int PIXELS_PER_PHASE = 150;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CHAN_W-1:0]   req_red;
   logic [CHAN_W-1:0]   req_green;
   logic [CHAN_W-1:0]   req_blue;
   logic                rsp_valid;
   logic [CHAN_W-1:0]   rsp_gray_level;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;
   int                  mismatch_count;
   int                  gray_in_flight;
   int                  gray_checked;
   int                  weight_settings;
   int                  reg_accesses;
   bit                  steady;

   srgb_luminance_gray_top dut (.*);

   slg_gray_checker gray_scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("[srgb_luminance_gray_top] ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CHAN_W-1:0] pick_channel();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         return CHAN_W'($urandom_range(0, 255));
      end
      if (roll < 70) begin
         return roll[0] ? 8'd255 : 8'd0;
      end
      if (roll < 85) begin
         return CHAN_W'($urandom_range(6, 16));
      end
      return CHAN_W'($urandom_range(0, 3) + (roll[1] ? 252 : 0));
   endfunction

   task automatic send_pixel(input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
      bit took;
      int gap;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      start <= 1'b1;
      do begin
         @(negedge clock);
         took = !busy;
         @(posedge clock);
      end while (!took);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (gray_in_flight != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic apb_access(input bit is_write, input reg_index_type idx,
                             input logic [DATA_W-1:0] value);
      bit rdy;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = pready;
         @(posedge clock);
      end while (!rdy);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      reg_accesses++;
      @(posedge clock);
   endtask

   task automatic load_weights(input logic [WEIGHT_W-1:0] wr,
                               input logic [WEIGHT_W-1:0] wg,
                               input logic [WEIGHT_W-1:0] wb);
      apb_access(1'b1, REG_WEIGHT_RED, {16'($urandom()), wr});
      apb_access(1'b1, REG_WEIGHT_GREEN, {16'($urandom()), wg});
      apb_access(1'b1, REG_WEIGHT_BLUE, {16'($urandom()), wb});
      apb_access(1'b1, REG_UNMAPPED, $urandom());
      apb_access(1'b0, REG_WEIGHT_RED, '0);
      apb_access(1'b0, REG_WEIGHT_GREEN, '0);
      apb_access(1'b0, REG_WEIGHT_BLUE, '0);
      weight_settings++;
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight(input bit full_range);
      if (full_range) begin
         return WEIGHT_W'($urandom());
      end
      return WEIGHT_W'($urandom_range(0, 32768));
   endfunction

   initial begin
      logic [CHAN_W-1:0] c;
      bit                wide;
      reset = 1'b1;
      start = 1'b0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      weight_settings = 1;
      reg_accesses = 0;
      steady = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset weights: extremes, primaries, linear segment edge
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd10, 8'd10, 8'd10);
      send_pixel(8'd11, 8'd11, 8'd11);
      send_pixel(8'd10, 8'd11, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd254, 8'd127);
      drain();

      // full-scale weights: sum above one saturates
      load_weights(16'd32768, 16'd32768, 16'd32768);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd200, 8'd200, 8'd200);
      send_pixel(8'd11, 8'd10, 8'd0);
      drain();

      load_weights(16'd0, 16'd0, 16'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd64, 8'd32);
      drain();

      // every weight bit set
      load_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd1, 8'd1, 8'd1);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd20, 8'd0, 8'd0);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wide = ($urandom_range(0, 3) == 0);
         if (ph == 0) begin
            load_weights(WEIGHT_RED_RESET, WEIGHT_GREEN_RESET, WEIGHT_BLUE_RESET);
         end else begin
            load_weights(pick_weight(wide), pick_weight(wide), pick_weight(wide));
         end
         steady = (ph % 3 == 1);
         for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
            if ($urandom_range(0, 99) < 15) begin
               c = pick_channel();
               send_pixel(c, c, c);
            end else begin
               send_pixel(pick_channel(), pick_channel(), pick_channel());
            end
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("%0d pixels compared under %0d weight settings, %0d register accesses",
               gray_checked, weight_settings, reg_accesses);
      if (mismatch_count == 0) begin
         $display("[srgb_luminance_gray_top] OK");
      end else begin
         $display("[srgb_luminance_gray_top] ERROR");
      end
      $finish;
   end

endmodule
